FILE: hw/rtl/osm_pkg.sv
// Shared constants and types for the order-statistic multiset block.
// No dependencies.
`default_nettype none
package osm_pkg;
  localparam int CAPACITY   = 1024;
  localparam int COUNT_BITS = 16;
  localparam int IDX_BITS   = $clog2(CAPACITY);
  localparam int USED_BITS  = $clog2(CAPACITY + 1);

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_RANK   = 3'd2;
  localparam logic [2:0] OP_KTH    = 3'd3;
  localparam logic [2:0] OP_PRED   = 3'd4;
  localparam logic [2:0] OP_SUCC   = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic start;   // latch word, reset scan
    logic check;   // evaluate read data of scan slot
    logic prep;    // set up move index and direction
    logic mv_rd;   // read move source slot
    logic mv_wr;   // write move destination slot
    logic wr;      // write new or updated entry at pos
    logic fin;     // update totals, load output
  } osm_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic mv_done;
    logic need_mv;
    logic need_wr;
  } osm_sts_t;
endpackage
`default_nettype wire

FILE: hw/rtl/osm_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module osm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/osm_datapath.sv
// Datapath: sorted value/count tables, scan, shift and result logic.
// Depends on osm_pkg, osm_ram.
`default_nettype none
module osm_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire osm_pkg::osm_cmd_t cmd,
  output osm_pkg::osm_sts_t      sts,
  input  wire logic [2:0]        in_kind,
  input  wire logic [31:0]       in_operand,
  output logic      [31:0]       res_answer,
  output logic      [1:0]        res_status
);
  localparam int IB = osm_pkg::IDX_BITS;
  localparam int UB = osm_pkg::USED_BITS;
  localparam int CB = osm_pkg::COUNT_BITS;

  logic [2:0]    kind_r;
  logic [31:0]   key_r, raw_r;
  logic [UB-1:0] used_r, idx_r, pos_r;
  logic [CB-1:0] total_r;
  logic [31:0]   acc_r, seen_r;
  logic          found_r, hit_r, sel_ok_r, pred_ok_r, succ_ok_r;
  logic [31:0]   pred_r, sel_r, succ_r;
  logic [CB-1:0] hcnt_r;
  logic          up_r;
  logic [31:0]   ans_r, ans_nxt;
  logic [1:0]    stat_r, stat_nxt;
  logic          we;
  logic [UB-1:0] addr_w;
  logic [IB-1:0] addr;
  logic [31:0]   vw, vr;
  logic [CB-1:0] cw, cr, new_cnt;
  logic [31:0]   seen_n;
  logic          ins_new, del_last, upd_wr;

  assign seen_n = seen_r + 32'(cr);

  always_comb begin
    if (kind_r == osm_pkg::OP_INSERT) new_cnt = hit_r ? hcnt_r + CB'(1) : CB'(1);
    else new_cnt = hcnt_r - CB'(1);
  end

  // scan reads slot idx_r; moves read one slot away and write idx_r
  always_comb begin
    addr_w = idx_r;
    we = 1'b0; vw = vr; cw = cr;
    if (cmd.mv_rd) begin
      addr_w = up_r ? idx_r - UB'(1) : idx_r + UB'(1);
    end else if (cmd.mv_wr) begin
      we = 1'b1;
    end else if (cmd.wr) begin
      addr_w = pos_r; we = 1'b1; vw = key_r; cw = new_cnt;
    end
  end
  assign addr = addr_w[IB-1:0];

  osm_ram #(.WIDTH(32), .DEPTH(osm_pkg::CAPACITY)) u_val (
    .clk, .we, .addr, .wdata(vw), .rdata(vr));
  osm_ram #(.WIDTH(CB), .DEPTH(osm_pkg::CAPACITY)) u_cnt (
    .clk, .we, .addr, .wdata(cw), .rdata(cr));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0; total_r <= '0;
    end else if (cmd.start) begin
      kind_r <= in_kind; raw_r <= in_operand;
      key_r <= in_operand ^ 32'h8000_0000;
      idx_r <= '0; acc_r <= '0; seen_r <= '0; found_r <= 1'b0; hit_r <= 1'b0;
      pos_r <= used_r; sel_ok_r <= 1'b0; pred_ok_r <= 1'b0; succ_ok_r <= 1'b0;
      hcnt_r <= '0;
    end else if (cmd.check) begin
      seen_r <= seen_n;
      if (!sel_ok_r && seen_n >= raw_r) begin
        sel_ok_r <= 1'b1; sel_r <= vr;
      end
      if (vr < key_r) begin
        acc_r <= acc_r + 32'(cr); pred_ok_r <= 1'b1; pred_r <= vr;
      end else if (!found_r) begin
        found_r <= 1'b1; pos_r <= idx_r;
        hit_r <= (vr == key_r); hcnt_r <= cr;
        if (vr != key_r) begin succ_ok_r <= 1'b1; succ_r <= vr; end
      end else if (!succ_ok_r) begin
        succ_ok_r <= 1'b1; succ_r <= vr;
      end
      idx_r <= idx_r + UB'(1);
    end else if (cmd.prep) begin
      idx_r <= ins_new ? used_r : pos_r;
      up_r <= ins_new;
    end else if (cmd.mv_wr) begin
      if (up_r) idx_r <= idx_r - UB'(1);
      else idx_r <= idx_r + UB'(1);
    end else if (cmd.fin) begin
      ans_r <= ans_nxt; stat_r <= stat_nxt;
      if (kind_r == osm_pkg::OP_INSERT && stat_nxt == osm_pkg::ST_OK) begin
        total_r <= total_r + CB'(1);
        if (!hit_r) used_r <= used_r + UB'(1);
      end
      if (kind_r == osm_pkg::OP_DELETE && hit_r) begin
        total_r <= total_r - CB'(1);
        if (hcnt_r == CB'(1)) used_r <= used_r - UB'(1);
      end
    end
  end

  assign res_answer = ans_r;
  assign res_status = stat_r;

  assign ins_new  = kind_r == osm_pkg::OP_INSERT && !hit_r
                    && stat_nxt == osm_pkg::ST_OK;
  assign del_last = kind_r == osm_pkg::OP_DELETE && hit_r && hcnt_r == CB'(1);
  assign upd_wr   = (kind_r == osm_pkg::OP_INSERT && stat_nxt == osm_pkg::ST_OK) ||
                    (kind_r == osm_pkg::OP_DELETE && hit_r && hcnt_r != CB'(1));

  always_comb begin
    sts.scan_done = idx_r >= used_r;
    sts.mv_done   = up_r ? (idx_r == pos_r) : ((idx_r + UB'(1)) >= used_r);
    sts.need_mv   = ins_new || del_last;
    sts.need_wr   = upd_wr;
  end

  always_comb begin
    ans_nxt = '0;
    stat_nxt = osm_pkg::ST_OK;
    case (kind_r)
      osm_pkg::OP_INSERT: begin
        if (total_r == {CB{1'b1}} ||
            (!hit_r && used_r == UB'(osm_pkg::CAPACITY)))
          stat_nxt = osm_pkg::ST_FULL;
      end
      osm_pkg::OP_DELETE: if (!hit_r) stat_nxt = osm_pkg::ST_NONE;
      osm_pkg::OP_RANK: ans_nxt = acc_r + 32'd1;
      osm_pkg::OP_KTH: begin
        if (raw_r[31] || raw_r == '0 || raw_r > 32'(total_r) || !sel_ok_r)
          stat_nxt = osm_pkg::ST_NONE;
        else ans_nxt = sel_r ^ 32'h8000_0000;
      end
      osm_pkg::OP_PRED: begin
        if (!pred_ok_r) stat_nxt = osm_pkg::ST_NONE;
        else ans_nxt = pred_r ^ 32'h8000_0000;
      end
      osm_pkg::OP_SUCC: begin
        if (!succ_ok_r) stat_nxt = osm_pkg::ST_NONE;
        else ans_nxt = succ_r ^ 32'h8000_0000;
      end
      default: stat_nxt = osm_pkg::ST_NONE;
    endcase
  end
endmodule
`default_nettype wire

FILE: hw/rtl/order_statistic_multiset.sv
// Top level of the order-statistic multiset; one word in flight at a time.
// Each word does a linear scan of the used slots; a new value then shifts the later
// slots up and writes, removing the last copy shifts them down, and a successful
// insert or a delete with copies left writes; in_ready returns the cycle after the
// result is taken. Reset clears the FSM state and the used and element counters only;
// slots at or above the used count are never read, and in_ready is high right away.
`default_nettype none
module order_statistic_multiset (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_kind,
  input  wire logic [31:0] in_operand,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_answer,
  output logic [1:0]       out_status
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_MV   = 3'd3;
  localparam logic [2:0] S_MVWR = 3'd4;
  localparam logic [2:0] S_WR   = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]         state_r, state_nxt;
  osm_pkg::osm_cmd_t  cmd;
  osm_pkg::osm_sts_t  sts;

  osm_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .in_kind, .in_operand,
    .res_answer(out_answer), .res_status(out_status));

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin cmd.start = 1'b1; state_nxt = S_SCAN; end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          cmd.prep = 1'b1;
          if (sts.need_mv) state_nxt = S_MV;
          else if (sts.need_wr) state_nxt = S_WR;
          else state_nxt = S_FIN;
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin cmd.check = 1'b1; state_nxt = S_SCAN; end
      S_MV: begin
        if (sts.mv_done) begin
          state_nxt = sts.need_wr ? S_WR : S_FIN;
        end else begin
          cmd.mv_rd = 1'b1; state_nxt = S_MVWR;
        end
      end
      S_MVWR: begin cmd.mv_wr = 1'b1; state_nxt = S_MV; end
      S_WR: begin cmd.wr = 1'b1; state_nxt = S_FIN; end
      S_FIN: begin cmd.fin = 1'b1; state_nxt = S_OUT; end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign out_valid = state_r == S_OUT;
endmodule
`default_nettype wire

FILE: bench/order_statistic_multiset_test.sv
// Testbench for order_statistic_multiset: drives insert, delete and query words
// and checks each answer against a sorted-table predictor in a scoreboard class.
// Depends on osm_pkg and the order_statistic_multiset RTL.
`timescale 1ns / 1ps
`default_nettype none
module order_statistic_multiset_test;

  class multiset_scoreboard;
    int            vals[osm_pkg::CAPACITY];
    int            cnts[osm_pkg::CAPACITY];
    int            used;
    int            total;
    int            errors;
    logic [31:0]   exp_answer[$];
    logic [1:0]    exp_status[$];

    function new();
      used = 0;
      total = 0;
      errors = 0;
    endfunction

    function int lower_pos(int key);
      int i;
      i = 0;
      while (i < used && vals[i] < key) i++;
      return i;
    endfunction

    function int pending();
      return exp_answer.size();
    endfunction

    // apply one accepted word to the table and queue its answer
    function void note(logic [2:0] kind, logic [31:0] operand);
      int key;
      int pos;
      bit hit;
      int smaller;
      int seen;
      int i;
      logic [31:0] ans;
      logic [1:0]  st;
      key = operand;
      pos = lower_pos(key);
      hit = (pos < used) && (vals[pos] == key);
      ans = '0;
      st = osm_pkg::ST_OK;
      case (kind)
        osm_pkg::OP_INSERT: begin
          if (total >= (1 << osm_pkg::COUNT_BITS) - 1 ||
              (!hit && used >= osm_pkg::CAPACITY)) begin
            st = osm_pkg::ST_FULL;
          end else begin
            if (!hit) begin
              for (i = used; i > pos; i--) begin
                vals[i] = vals[i-1];
                cnts[i] = cnts[i-1];
              end
              vals[pos] = key;
              cnts[pos] = 0;
              used++;
            end
            cnts[pos]++;
            total++;
          end
        end
        osm_pkg::OP_DELETE: begin
          if (!hit) begin
            st = osm_pkg::ST_NONE;
          end else begin
            total--;
            if (cnts[pos] > 1) begin
              cnts[pos]--;
            end else begin
              for (i = pos; i + 1 < used; i++) begin
                vals[i] = vals[i+1];
                cnts[i] = cnts[i+1];
              end
              used--;
            end
          end
        end
        osm_pkg::OP_RANK: begin
          smaller = 0;
          for (i = 0; i < pos; i++) smaller += cnts[i];
          ans = smaller + 1;
        end
        osm_pkg::OP_KTH: begin
          if (key < 1 || key > total) begin
            st = osm_pkg::ST_NONE;
          end else begin
            seen = 0;
            for (i = 0; i < used; i++) begin
              seen += cnts[i];
              if (seen >= key) begin
                ans = vals[i];
                break;
              end
            end
          end
        end
        osm_pkg::OP_PRED: begin
          if (pos == 0) st = osm_pkg::ST_NONE;
          else ans = vals[pos-1];
        end
        osm_pkg::OP_SUCC: begin
          i = hit ? pos + 1 : pos;
          if (i >= used) st = osm_pkg::ST_NONE;
          else ans = vals[i];
        end
        default: st = osm_pkg::ST_NONE;
      endcase
      exp_answer.push_back(ans);
      exp_status.push_back(st);
    endfunction

    function void check(logic [31:0] answer, logic [1:0] status);
      logic [31:0] ea;
      logic [1:0]  es;
      if (exp_answer.size() == 0) begin
        $display("%0t: unexpected word answer=%0d status=%0d", $time,
                 $signed(answer), status);
        errors++;
        return;
      end
      ea = exp_answer.pop_front();
      es = exp_status.pop_front();
      if (answer !== ea) begin
        $display("%0t: answer mismatch expected %0d actual %0d", $time,
                 $signed(ea), $signed(answer));
        errors++;
      end
      if (status !== es) begin
        $display("%0t: status mismatch expected %0d actual %0d", $time, es, status);
        errors++;
      end
    endfunction
  endclass

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_kind = '0;
  logic [31:0] in_operand = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_answer;
  logic [1:0]  out_status;

  multiset_scoreboard sb = new();
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  int quiet_cycles = 0;

  order_statistic_multiset u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_operand(in_operand),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_answer(out_answer), .out_status(out_status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) sb.check(out_answer, out_status);
    if (hold_req) begin
      hold_cnt = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(0, 99) >= 33);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send(logic [2:0] kind, logic [31:0] operand);
    in_valid <= 1'b1;
    in_kind <= kind;
    in_operand <= operand;
    do @(posedge clk); while (!in_ready);
    sb.note(kind, operand);
  endtask

  task automatic maybe_gap();
    if (!no_idle && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic int pick_val();
    if ($urandom_range(0, 99) < 80) return int'($urandom_range(0, 80)) - 40;
    return int'($urandom_range(0, 2000)) - 1000;
  endfunction

  function automatic int stored_val();
    if (sb.used == 0) return pick_val();
    return sb.vals[$urandom_range(0, sb.used - 1)];
  endfunction

  task automatic random_word(bit queries_only);
    int r;
    logic [2:0] kind;
    logic [31:0] op;
    r = $urandom_range(0, 99);
    if (queries_only) r = $urandom_range(50, 99);
    else if (sb.used > 60 && r < 30) r = 30 + r / 2;
    if (r < 30) begin
      kind = osm_pkg::OP_INSERT;
      op = pick_val();
    end else if (r < 50) begin
      kind = osm_pkg::OP_DELETE;
      op = ($urandom_range(0, 9) < 7) ? stored_val() : pick_val();
    end else if (r < 96) begin
      kind = 3'($urandom_range(osm_pkg::OP_RANK, osm_pkg::OP_SUCC));
      case ($urandom_range(0, 9))
        0, 1: op = $urandom;
        2, 3, 4: op = pick_val();
        default: op = stored_val();
      endcase
      if (kind == osm_pkg::OP_KTH) begin
        if (sb.total > 0 && $urandom_range(0, 9) < 8) op = $urandom_range(1, sb.total);
        else if ($urandom_range(0, 1)) op = sb.total + 1;
      end
    end else begin
      kind = 3'($urandom_range(6, 7));
      op = $urandom;
    end
    send(kind, op);
  endtask

  initial begin
    int n;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty-store cases, extremes, duplicates, undefined kinds
    send(osm_pkg::OP_RANK, 32'd5);
    send(osm_pkg::OP_KTH, 32'd1);
    send(osm_pkg::OP_PRED, 32'd0);
    send(osm_pkg::OP_SUCC, 32'd0);
    send(osm_pkg::OP_DELETE, 32'd7);
    send(osm_pkg::OP_INSERT, 32'h8000_0000);
    send(osm_pkg::OP_INSERT, 32'h7fff_ffff);
    send(osm_pkg::OP_INSERT, 32'd0);
    send(osm_pkg::OP_INSERT, 32'd0);
    send(osm_pkg::OP_INSERT, 32'hffff_ffff);
    send(osm_pkg::OP_RANK, 32'd0);
    send(osm_pkg::OP_RANK, 32'h7fff_ffff);
    send(osm_pkg::OP_KTH, 32'd1);
    send(osm_pkg::OP_KTH, 32'd5);
    send(osm_pkg::OP_KTH, 32'd0);
    send(osm_pkg::OP_KTH, 32'hffff_ffff);
    send(osm_pkg::OP_KTH, 32'd6);
    send(osm_pkg::OP_PRED, 32'h8000_0000);
    send(osm_pkg::OP_PRED, 32'h7fff_ffff);
    send(osm_pkg::OP_SUCC, 32'h7fff_ffff);
    send(osm_pkg::OP_SUCC, 32'h8000_0000);
    send(osm_pkg::OP_SUCC, 32'd0);
    send(3'd6, 32'd0);
    send(3'd7, 32'hffff_ffff);
    send(osm_pkg::OP_DELETE, 32'd0);
    send(osm_pkg::OP_DELETE, 32'h7fff_ffff);
    send(osm_pkg::OP_DELETE, 32'h8000_0000);
    send(osm_pkg::OP_DELETE, 32'd0);
    send(osm_pkg::OP_DELETE, 32'hffff_ffff);

    for (n = 0; n < 800; n++) begin
      no_idle = (n >= 400 && n < 600);
      if (n == 100) hold_req = 1'b1;
      if (n == 300) pause_until_drained();
      maybe_gap();
      random_word(1'b0);
    end
    no_idle = 1'b0;

    // fill the table by appending above every stored value
    n = 2000;
    while (sb.used < osm_pkg::CAPACITY) begin
      maybe_gap();
      send(osm_pkg::OP_INSERT, n);
      n++;
    end
    send(osm_pkg::OP_INSERT, 32'd5000000);
    send(osm_pkg::OP_INSERT, 32'hffff_ec78);
    send(osm_pkg::OP_INSERT, 32'd2000);
    for (n = 0; n < 60; n++) begin
      maybe_gap();
      random_word(1'b1);
    end
    send(osm_pkg::OP_DELETE, 32'd2001);
    send(osm_pkg::OP_INSERT, 32'd1000000);
    send(osm_pkg::OP_INSERT, 32'd1000001);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * osm_pkg::CAPACITY + 50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
